// ===== sv/ipv4f_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4f_pkg
// Types, microcode store and digit split for the dotted-decimal formatter.
// ----------------------------------------------------------------------------
package ipv4f_pkg;

    localparam int unsigned STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    // Microcode addresses
    localparam t_step STEP_IDLE = 3'd0;
    localparam t_step STEP_LOAD = 3'd1;
    localparam t_step STEP_HUND = 3'd2;
    localparam t_step STEP_TENS = 3'd3;
    localparam t_step STEP_ONES = 3'd4;
    localparam t_step STEP_DOT  = 3'd5;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_DOT  = 8'h2e;
    localparam logic [1:0] LAST_BYTE  = 2'd3;

    typedef enum logic [1:0] {
        SEL_HUND,
        SEL_TENS,
        SEL_ONES,
        SEL_DOT
    } t_char_sel;

    typedef enum logic [1:0] {
        SKIP_NEVER,
        SKIP_HUND_ZERO,
        SKIP_UPPER_ZERO
    } t_skip_cond;

    typedef struct packed {
        logic       wait_in;     // hold here until an address transaction
        logic       load_digits; // split current byte into decimal digits
        logic       emit;        // write one character to the output register
        t_char_sel  sel;
        t_skip_cond skip;
        logic       fin_check;   // on the last byte, end of text: jump to alt
        logic       next_byte;   // advance to the following address byte
        t_step      nxt;
        t_step      alt;
    } t_uword;

    typedef struct packed {
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_bcd;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{wait_in: 1'b0, load_digits: 1'b0, emit: 1'b0, sel: SEL_DOT,
              skip: SKIP_NEVER, fin_check: 1'b0, next_byte: 1'b0,
              nxt: STEP_IDLE, alt: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                w.wait_in = 1'b1;
                w.nxt     = STEP_LOAD;
            end
            STEP_LOAD: begin
                w.load_digits = 1'b1;
                w.nxt         = STEP_HUND;
            end
            STEP_HUND: begin
                w.emit = 1'b1;
                w.sel  = SEL_HUND;
                w.skip = SKIP_HUND_ZERO;
                w.nxt  = STEP_TENS;
            end
            STEP_TENS: begin
                w.emit = 1'b1;
                w.sel  = SEL_TENS;
                w.skip = SKIP_UPPER_ZERO;
                w.nxt  = STEP_ONES;
            end
            STEP_ONES: begin
                w.emit      = 1'b1;
                w.sel       = SEL_ONES;
                w.fin_check = 1'b1;
                w.nxt       = STEP_DOT;
                w.alt       = STEP_IDLE;
            end
            STEP_DOT: begin
                w.emit      = 1'b1;
                w.sel       = SEL_DOT;
                w.next_byte = 1'b1;
                w.nxt       = STEP_LOAD;
            end
            default: begin
                w.nxt = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // v / 10 as (v * 205) >> 11, exact for v below 1024
    function automatic t_bcd to_bcd(input logic [7:0] v);
        logic [15:0] p1;
        logic [4:0]  q1;
        logic [12:0] p2;
        logic [1:0]  q2;
        t_bcd        r;
        p1 = {8'd0, v} * 16'd205;
        q1 = p1[15:11];
        p2 = {8'd0, q1} * 13'd205;
        q2 = p2[12:11];
        r.hund = q2;
        r.tens = 4'(q1 - 5'(q2) * 5'd10);
        r.ones = 4'(v - 8'(q1) * 8'd10);
        return r;
    endfunction

endpackage

// ===== sv/ipv4_dotted_decimal_formatter.sv =====
// ----------------------------------------------------------------------------
// ipv4_dotted_decimal_formatter
// Prints a 32-bit IPv4 address as dotted-decimal ASCII, one character per
// output transaction.
// ----------------------------------------------------------------------------
//  Channel  Signals                                        Direction
//  in       i_in_valid / o_in_ready, i_address_in          address in
//  out      o_out_valid / i_out_ready, o_text_char,        characters out
//           o_last_char, o_text_length
//
//  Steps: one idle step that takes the transaction, then per byte a
//  digit-split step and three digit steps, plus three dot steps, whatever
//  the text length (7..15). A suppressed leading zero still spends its
//  step, so a short text ends no sooner than a long one.
//  Reset (i_rst_n low, synchronous) returns the sequencer to its idle step
//  and empties the output register. A stalled output holds any emit step
//  that writes a character; the next address is taken only from the idle step.
// ----------------------------------------------------------------------------
module ipv4_dotted_decimal_formatter
    import ipv4f_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_address_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_text_char,
    output logic        o_last_char,
    output logic [3:0]  o_text_length
);

    // Sequencer state
    t_step       r_step, n_step;
    logic [1:0]  r_byte, n_byte;
    logic [3:0]  r_len, n_len;

    // Datapath
    logic [31:0] r_addr, n_addr;
    t_bcd        r_bcd, n_bcd;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_char, n_char;
    logic        r_last, n_last;
    logic [3:0]  r_tlen, n_tlen;

    t_uword      uw;
    logic        skip;
    logic        out_busy;
    logic        fire;
    logic        is_last;
    logic [7:0]  ch;

    assign uw       = ucode(r_step);
    assign out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        case (uw.skip)
            SKIP_HUND_ZERO:  skip = (r_bcd.hund == 2'd0);
            SKIP_UPPER_ZERO: skip = (r_bcd.hund == 2'd0) && (r_bcd.tens == 4'd0);
            default:         skip = 1'b0;
        endcase
    end

    always_comb begin
        case (uw.sel)
            SEL_HUND: ch = ASCII_ZERO + {6'd0, r_bcd.hund};
            SEL_TENS: ch = ASCII_ZERO + {4'd0, r_bcd.tens};
            SEL_ONES: ch = ASCII_ZERO + {4'd0, r_bcd.ones};
            default:  ch = ASCII_DOT;
        endcase
    end

    assign o_in_ready = uw.wait_in;
    assign fire       = uw.emit && !skip && !out_busy;
    assign is_last    = uw.fin_check && (r_byte == LAST_BYTE);

    // Next state: one control word per step; writing steps hold on a stall
    always_comb begin
        n_step      = r_step;
        n_byte      = r_byte;
        n_len       = r_len;
        n_addr      = r_addr;
        n_bcd       = r_bcd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_last      = r_last;
        n_tlen      = r_tlen;

        if (uw.wait_in) begin
            if (i_in_valid) begin
                n_addr = i_address_in;
                n_byte = 2'd0;
                n_len  = 4'd0;
                n_step = uw.nxt;
            end
        end else if (uw.load_digits) begin
            n_bcd  = to_bcd(r_addr[31:24]);
            n_step = uw.nxt;
        end else if (uw.emit) begin
            if (skip) begin
                n_step = uw.nxt;
            end else if (fire) begin
                n_out_valid = 1'b1;
                n_char      = ch;
                n_last      = is_last;
                n_tlen      = is_last ? r_len + 4'd1 : 4'd0;
                n_len       = r_len + 4'd1;
                n_step      = is_last ? uw.alt : uw.nxt;
                if (uw.next_byte) begin
                    n_byte = r_byte + 2'd1;
                    n_addr = {r_addr[23:0], 8'd0};
                end
            end
        end else begin
            n_step = uw.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_byte      <= 2'd0;
            r_len       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_byte      <= n_byte;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
        r_tlen <= n_tlen;
    end

    assign o_out_valid   = r_out_valid;
    assign o_text_char   = r_char;
    assign o_last_char   = r_last;
    assign o_text_length = r_tlen;

endmodule
